FILE: rtl/core/detector_event_builder_macros.svh
// Assertion macros shared by the detector event builder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DETECTOR_EVENT_BUILDER_MACROS_SVH
`define DETECTOR_EVENT_BUILDER_MACROS_SVH
`ifndef SYNTHESIS
`define DEB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("detector_event_builder: assertion failed");
`define DEB_ASSERT_NEXT(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("detector_event_builder: assertion failed");
`else
`define DEB_ASSERT(label, clk, rst_n, prop)
`define DEB_ASSERT_NEXT(label, clk, rst_n, cond, res)
`endif
`endif

FILE: rtl/core/deb_pkg.sv
// Package for the detector event builder: field widths, codes and types.
// Used by deb_out_fifo and detector_event_builder; depends on nothing.
`default_nettype none

package deb_pkg;

    localparam int DEB_NUM_CHANNELS = 64;

    localparam int CHAN_W   = 6;
    localparam int TIME_W   = 48;
    localparam int DEP_E_W  = 24;
    localparam int EV_E_W   = 32;
    localparam int WIN_W    = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_WIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_WIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_E_THRESH  = 2'd2;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 88;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic {
        CMD_DEPOSIT = 1'b0,
        CMD_FLUSH   = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [EV_E_W-1:0] energy;
        logic [TIME_W-1:0] start;
        logic [CHAN_W-1:0] chan;
    } t_event;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [EV_E_W-1:0] energy;
    } t_pend;

    typedef struct packed {
        logic               vld;
        logic [FIFO_CW-1:0] cnt;
    } t_ofifo_stat;

endpackage

`default_nettype wire

FILE: rtl/core/deb_out_fifo.sv
// Four-entry result queue between the event logic and the output beat.
// Depends on deb_pkg and detector_event_builder_macros.svh.
`default_nettype none
`include "detector_event_builder_macros.svh"

module deb_out_fifo import deb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_event      i_push_data,
    input  wire logic        i_pop,
    output t_event           o_head,
    output t_ofifo_stat      o_stat
);

    t_event             r_buf [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_cnt;
    logic [FIFO_CW-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + FIFO_CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - FIFO_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head     = r_buf[r_rd_ptr];
    assign o_stat.vld = (r_cnt != '0);
    assign o_stat.cnt = r_cnt;

    `DEB_ASSERT(a_pop_not_empty, i_clk, i_rst_n, i_pop |-> (r_cnt != '0))
    `DEB_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, i_push && !i_pop,
        r_cnt == $past(r_cnt) + FIFO_CW'(1))
    `DEB_ASSERT_NEXT(a_first_head, i_clk, i_rst_n, i_push && (r_cnt == '0),
        o_head == $past(i_push_data))

endmodule

`default_nettype wire

FILE: rtl/core/detector_event_builder.sv
// Per-channel detector event builder with integration and dead windows.
// Depends on deb_pkg, deb_out_fifo and detector_event_builder_macros.svh.
//
// Deposits and flush commands enter on the s_axis channel: tuser carries the
// command and tdata the channel, time and energy of the deposit. Closed events
// whose energy reaches the threshold leave on the m_axis channel.
// Window and threshold registers are written through the cfg port; the user
// must write them only while idle, which the block itself does not enforce.
// One beat is taken per clock cycle while s_axis_tready is high. A beat
// accepted at one edge reads its channel entry from the state memory at that
// edge, is resolved in the next cycle and, if it closes an event, is pushed
// into the result queue at the next edge. The state memory read is registered;
// the entry written by the beat just ahead is forwarded from a holding register.
// Results wait in a four-entry queue. When the receiver stalls, s_axis_tready
// falls once queued results plus the beat in flight fill the queue, so no
// result is lost. Synchronous reset clears the pending flags of all channels,
// the configuration registers and the queue.
`default_nettype none
`include "detector_event_builder_macros.svh"

module detector_event_builder import deb_pkg::*; #(
    parameter int NUM_CHANNELS = DEB_NUM_CHANNELS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [5:0] channel, [53:6] deposit_time, [77:54] deposit_energy, rest zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [5:0] event_channel, [53:6] event_time, [85:54] event_energy, rest zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int DEPTH = (NUM_CHANNELS < (1 << CHAN_W)) ? NUM_CHANNELS : (1 << CHAN_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [12:0] NCH = 13'(NUM_CHANNELS);

    logic [WIN_W-1:0]   r_integ_win;
    logic [WIN_W-1:0]   r_dead_win;
    logic [EV_E_W-1:0]  r_thresh;

    t_pend              r_mem [DEPTH];
    t_pend              r_rd_data;
    logic [DEPTH-1:0]   r_pend_vld;

    logic               r_fwd_vld;
    logic [AW-1:0]      r_fwd_idx;
    t_pend              r_fwd_data;

    logic               r_s1_vld;
    t_cmd               r_s1_cmd;
    logic [CHAN_W-1:0]  r_s1_ch;
    logic [TIME_W-1:0]  r_s1_time;
    logic [DEP_E_W-1:0] r_s1_energy;

    logic               w_acc;
    logic [AW-1:0]      w_in_idx;
    logic [AW-1:0]      w_s1_idx;
    logic               w_in_range;
    logic               w_cur_vld;
    t_pend              w_cur;
    logic [TIME_W:0]    w_lim_integ;
    logic [TIME_W:0]    w_lim_dead;
    logic               w_lt_integ;
    logic               w_lt_dead;
    logic               w_lt_start;
    logic [EV_E_W:0]    w_sum;
    logic [EV_E_W-1:0]  w_sat_sum;
    logic               w_close_ok;
    logic               n_wr_en;
    t_pend              n_wr_data;
    logic               n_vld_set;
    logic               n_vld_clr;
    logic               w_emit;
    t_event             w_event;
    t_event             w_head;
    t_ofifo_stat        w_fifo_stat;
    logic [FIFO_CW:0]   w_in_flight;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_win <= '0;
            r_dead_win  <= '0;
            r_thresh    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_INTEG_WIN: r_integ_win <= i_cfg_wdata[WIN_W-1:0];
                CFG_DEAD_WIN:  r_dead_win  <= i_cfg_wdata[WIN_W-1:0];
                CFG_E_THRESH:  r_thresh    <= i_cfg_wdata[EV_E_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_in_flight   = {1'b0, w_fifo_stat.cnt} + {{FIFO_CW{1'b0}}, r_s1_vld};
    assign s_axis_tready = i_rst_n && (w_in_flight < (FIFO_CW + 1)'(FIFO_DEPTH));
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_in_idx      = s_axis_tdata[AW-1:0];
    assign w_s1_idx      = r_s1_ch[AW-1:0];

    // Input stage: register the beat and read its channel entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_cmd    <= t_cmd'(s_axis_tuser);
            r_s1_ch     <= s_axis_tdata[CHAN_W-1:0];
            r_s1_time   <= s_axis_tdata[CHAN_W +: TIME_W];
            r_s1_energy <= s_axis_tdata[CHAN_W + TIME_W +: DEP_E_W];
            r_rd_data   <= r_mem[w_in_idx];
        end
        if (n_wr_en) begin
            r_mem[w_s1_idx] <= n_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else begin
            r_fwd_vld <= n_wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_fwd_idx  <= w_s1_idx;
            r_fwd_data <= n_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= '0;
        end else if (n_vld_set) begin
            r_pend_vld[w_s1_idx] <= 1'b1;
        end else if (n_vld_clr) begin
            r_pend_vld[w_s1_idx] <= 1'b0;
        end
    end

    // Resolve stage: decide merge, drop, close or open, and write back.
    assign w_in_range  = {7'b0, r_s1_ch} < NCH;
    assign w_cur_vld   = r_pend_vld[w_s1_idx];
    assign w_cur       = (r_fwd_vld && (r_fwd_idx == w_s1_idx)) ? r_fwd_data : r_rd_data;
    assign w_lim_integ = {1'b0, w_cur.start} + {{(TIME_W + 1 - WIN_W){1'b0}}, r_integ_win};
    assign w_lim_dead  = {1'b0, w_cur.start} + {{(TIME_W + 1 - WIN_W){1'b0}}, r_dead_win};
    assign w_lt_integ  = {1'b0, r_s1_time} < w_lim_integ;
    assign w_lt_dead   = {1'b0, r_s1_time} < w_lim_dead;
    assign w_lt_start  = r_s1_time < w_cur.start;
    assign w_sum       = {1'b0, w_cur.energy} + {{(EV_E_W + 1 - DEP_E_W){1'b0}}, r_s1_energy};
    assign w_sat_sum   = w_sum[EV_E_W] ? {EV_E_W{1'b1}} : w_sum[EV_E_W-1:0];
    assign w_close_ok  = w_cur.energy >= r_thresh;

    always_comb begin
        n_wr_en   = 1'b0;
        n_wr_data = w_cur;
        n_vld_set = 1'b0;
        n_vld_clr = 1'b0;
        w_emit    = 1'b0;
        if (r_s1_vld && w_in_range) begin
            if (r_s1_cmd == CMD_FLUSH) begin
                if (w_cur_vld) begin
                    n_vld_clr = 1'b1;
                    w_emit    = w_close_ok;
                end
            end else if (!w_cur_vld) begin
                n_wr_en   = 1'b1;
                n_wr_data = '{start: r_s1_time, energy: EV_E_W'(r_s1_energy)};
                n_vld_set = 1'b1;
            end else if (w_lt_integ) begin
                if (r_s1_energy != '0) begin
                    n_wr_en          = 1'b1;
                    n_wr_data.energy = w_sat_sum;
                    n_wr_data.start  = w_lt_start ? r_s1_time : w_cur.start;
                end
            end else if (!w_lt_dead) begin
                w_emit    = w_close_ok;
                n_wr_en   = 1'b1;
                n_wr_data = '{start: r_s1_time, energy: EV_E_W'(r_s1_energy)};
            end
        end
    end

    assign w_event = '{energy: w_cur.energy, start: w_cur.start, chan: r_s1_ch};

    deb_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_emit),
        .i_push_data (w_event),
        .i_pop       (m_axis_tvalid && m_axis_tready),
        .o_head      (w_head),
        .o_stat      (w_fifo_stat)
    );

    assign m_axis_tvalid = w_fifo_stat.vld;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_event)){1'b0}}, w_head};

    `DEB_ASSERT(a_emit_room, i_clk, i_rst_n,
        w_emit |-> (w_fifo_stat.cnt < FIFO_CW'(FIFO_DEPTH)))
    `DEB_ASSERT_NEXT(a_acc_to_s1, i_clk, i_rst_n, w_acc, r_s1_vld)
    `DEB_ASSERT(a_flush_no_write, i_clk, i_rst_n,
        (r_s1_vld && (r_s1_cmd == CMD_FLUSH)) |-> (!n_wr_en && !n_vld_set))

endmodule

`default_nettype wire
